### rtl/core/mlr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the midpoint line rasterizer.
// No dependencies; every other file of the block imports this package.
package mlr_pkg;

    localparam int COORD_W   = 6;   // pixel coordinate
    localparam int CFG_W     = 7;   // frame width / height registers
    localparam int CFG_IDX_W = 1;   // configuration register index
    localparam int INDEX_W   = 12;  // emitted linear index
    localparam int PROD_W    = 14;  // full linear index and frame area
    localparam int DEC_W     = 10;  // doubled decision variable, signed

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 7'd64;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 7'd64;

    typedef logic [COORD_W-1:0]      t_coord;
    typedef logic signed [DEC_W-1:0] t_dec;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_RUN
    } t_walk_state;

    // pixel handed from the walker to the output stage
    typedef struct packed {
        logic   valid;
        t_coord x;
        t_coord y;
        logic   last;
    } t_pix_push;

endpackage

### rtl/core/mlr_intf.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: segment input and pixel output.
// Depends on mlr_pkg for field widths.
interface mlr_seg_if;
    import mlr_pkg::*;

    logic   valid;
    logic   ready;
    t_coord start_x;
    t_coord start_y;
    t_coord end_x;
    t_coord end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface mlr_pix_if;
    import mlr_pkg::*;

    logic                 valid;
    logic                 ready;
    t_coord               pixel_x;
    t_coord               pixel_y;
    logic [INDEX_W-1:0]   pixel_index;
    logic                 in_frame;
    logic                 last;

    modport source (output valid, pixel_x, pixel_y, pixel_index, in_frame, last,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_index, in_frame, last,
                    output ready);
endinterface

### rtl/core/mlr_walker.sv
`timescale 1ns / 1ps
// Segment sequencer: orders the endpoints, then steps the doubled midpoint
// decision variable through one shared adder, one pixel per step. Uses mlr_pkg.
module mlr_walker #(
    parameter int GRID_SIZE = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mlr_seg_if.sink            i_seg,
    output mlr_pkg::t_pix_push o_push,
    input  logic               i_slot_ready
);
    import mlr_pkg::*;

    localparam int CNT_W = $clog2(GRID_SIZE + 1);

    t_walk_state r_state, n_state;
    t_coord      r_x, n_x;
    t_coord      r_y, n_y;
    logic        r_xneg, n_xneg;
    logic        r_shallow, n_shallow;
    t_coord      r_len, n_len;
    t_coord      r_minor, n_minor;
    t_coord      r_diff, n_diff;
    t_dec        r_dec, n_dec;
    t_dec        r_inc_lt, n_inc_lt;
    t_dec        r_inc_ge, n_inc_ge;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // segment decode from the input payload
    logic   swap;
    t_coord st_x, st_y, ot_x;
    t_coord adx, ady;
    logic   shallow;
    t_coord len, minor;
    logic [COORD_W:0] len_p1;

    // shared decision adder
    t_dec add_a, add_b, add_sum;
    t_dec len_d, min_d, diff_d;

    always_comb begin
        swap    = (i_seg.start_y == i_seg.end_y) ? (i_seg.end_x < i_seg.start_x)
                                                 : (i_seg.end_y < i_seg.start_y);
        st_x    = swap ? i_seg.end_x   : i_seg.start_x;
        st_y    = swap ? i_seg.end_y   : i_seg.start_y;
        ot_x    = swap ? i_seg.start_x : i_seg.end_x;
        adx     = (i_seg.start_x > i_seg.end_x) ? (i_seg.start_x - i_seg.end_x)
                                                : (i_seg.end_x - i_seg.start_x);
        ady     = (i_seg.start_y > i_seg.end_y) ? (i_seg.start_y - i_seg.end_y)
                                                : (i_seg.end_y - i_seg.start_y);
        shallow = (ady <= adx);
        len     = shallow ? adx : ady;
        minor   = shallow ? ady : adx;
        len_p1  = {1'b0, len} + {{COORD_W{1'b0}}, 1'b1};
    end

    assign len_d  = {{(DEC_W-COORD_W){1'b0}}, r_len};
    assign min_d  = {{(DEC_W-COORD_W){1'b0}}, r_minor};
    assign diff_d = {{(DEC_W-COORD_W){1'b0}}, r_diff};

    always_comb begin
        if (r_state == ST_RUN) begin
            add_a = r_dec;
            add_b = r_dec[DEC_W-1] ? r_inc_lt : r_inc_ge;
        end else begin
            // initial value: L - 2m for x-major, 2m - L for y-major
            add_a = r_shallow ? len_d : (min_d <<< 1);
            add_b = r_shallow ? -(min_d <<< 1) : -len_d;
        end
    end

    assign add_sum = add_a + add_b;

    assign i_seg.ready   = (r_state == ST_IDLE);
    assign o_push.valid  = (r_state == ST_RUN);
    assign o_push.x      = r_x;
    assign o_push.y      = r_y;
    assign o_push.last   = (r_cnt == CNT_W'(1));

    always_comb begin
        n_state   = r_state;
        n_x       = r_x;
        n_y       = r_y;
        n_xneg    = r_xneg;
        n_shallow = r_shallow;
        n_len     = r_len;
        n_minor   = r_minor;
        n_diff    = r_diff;
        n_dec     = r_dec;
        n_inc_lt  = r_inc_lt;
        n_inc_ge  = r_inc_ge;
        n_cnt     = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_seg.valid) begin
                    n_x       = st_x;
                    n_y       = st_y;
                    n_xneg    = (st_x > ot_x);
                    n_shallow = shallow;
                    n_len     = len;
                    n_minor   = minor;
                    n_diff    = len - minor;
                    if (32'(len_p1) > 32'(GRID_SIZE)) begin
                        n_cnt = CNT_W'(GRID_SIZE);
                    end else begin
                        n_cnt = CNT_W'(len_p1);
                    end
                    n_state   = ST_INIT;
                end
            end
            ST_INIT: begin
                n_dec    = add_sum;
                n_inc_lt = r_shallow ? (diff_d <<< 1) : (min_d <<< 1);
                n_inc_ge = r_shallow ? -(min_d <<< 1) : -(diff_d <<< 1);
                n_state  = ST_RUN;
            end
            ST_RUN: begin
                if (i_slot_ready) begin
                    n_dec = add_sum;
                    n_cnt = r_cnt - CNT_W'(1);
                    if (r_shallow) begin
                        n_x = r_xneg ? (r_x - t_coord'(1)) : (r_x + t_coord'(1));
                        if (r_dec[DEC_W-1]) begin
                            n_y = r_y + t_coord'(1);
                        end
                    end else begin
                        n_y = r_y + t_coord'(1);
                        if (!r_dec[DEC_W-1]) begin
                            n_x = r_xneg ? (r_x - t_coord'(1)) : (r_x + t_coord'(1));
                        end
                    end
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_y       <= n_y;
        r_xneg    <= n_xneg;
        r_shallow <= n_shallow;
        r_len     <= n_len;
        r_minor   <= n_minor;
        r_diff    <= n_diff;
        r_dec     <= n_dec;
        r_inc_lt  <= n_inc_lt;
        r_inc_ge  <= n_inc_ge;
    end

endmodule

### rtl/core/mlr_pixel_out.sv
`timescale 1ns / 1ps
// Frame registers, linear index and frame bound check, and the output
// register of the pixel channel. Uses mlr_pkg and mlr_pix_if.
module mlr_pixel_out (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mlr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mlr_pkg::CFG_W-1:0]          i_cfg_data,
    input  mlr_pkg::t_pix_push                 i_push,
    output logic                               o_slot_ready,
    mlr_pix_if.source                          o_pix
);
    import mlr_pkg::*;

    logic [CFG_W-1:0]   r_width;
    logic [CFG_W-1:0]   r_height;
    logic               r_valid;
    t_coord             r_x;
    t_coord             r_y;
    logic [INDEX_W-1:0] r_index;
    logic               r_in_frame;
    logic               r_last;

    logic [PROD_W-1:0]  idx_full;
    logic [PROD_W-1:0]  area;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= FRAME_WIDTH_RST;
            r_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign idx_full = PROD_W'(i_push.y) * PROD_W'(r_width) + PROD_W'(i_push.x);
    assign area     = PROD_W'(r_width) * PROD_W'(r_height);

    assign o_slot_ready = !r_valid || o_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_slot_ready) begin
            r_valid <= i_push.valid;
        end
    end

    // load on every push; hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (o_slot_ready && i_push.valid) begin
            r_x        <= i_push.x;
            r_y        <= i_push.y;
            r_index    <= idx_full[INDEX_W-1:0];
            r_in_frame <= (idx_full < area);
            r_last     <= i_push.last;
        end
    end

    assign o_pix.valid       = r_valid;
    assign o_pix.pixel_x     = r_x;
    assign o_pix.pixel_y     = r_y;
    assign o_pix.pixel_index = r_index;
    assign o_pix.in_frame    = r_in_frame;
    assign o_pix.last        = r_last;

endmodule

### rtl/core/midpoint_line_rasterizer_top.sv
`timescale 1ns / 1ps
// Midpoint line rasterizer: takes one segment per transfer and emits its pixels,
// each with a linear frame index, an in-frame flag and a last flag. The input
// is not ready while a segment is being walked. After a segment transfer the
// decision variable is loaded, and then the walker emits one pixel per cycle
// while the pixel sink does not stall, max(|dx|,|dy|)+1 pixels capped at
// GRID_SIZE; the single decision-variable adder steps once per pixel. A pixel
// that waits in the output register does not block the next segment transfer
// after the last pixel.
// frame_width and frame_height must be written while no segment is in flight.
// Depends on mlr_pkg, mlr_intf, mlr_walker and mlr_pixel_out.
module midpoint_line_rasterizer_top #(
    parameter int GRID_SIZE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mlr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mlr_pkg::CFG_W-1:0]     i_cfg_data,
    mlr_seg_if.sink                       i_seg,
    mlr_pix_if.source                     o_pix
);
    import mlr_pkg::*;

    t_pix_push push;
    logic      slot_ready;

    mlr_walker #(
        .GRID_SIZE (GRID_SIZE)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seg        (i_seg),
        .o_push       (push),
        .i_slot_ready (slot_ready)
    );

    mlr_pixel_out u_pixel_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .o_slot_ready (slot_ready),
        .o_pix        (o_pix)
    );

endmodule

### rtl/core/mlr_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the midpoint line rasterizer, bound to its top level.
// Depends on mlr_pkg and midpoint_line_rasterizer_top.
module mlr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_seg_valid,
    input logic                        i_seg_ready,
    input logic                        i_pix_valid,
    input logic                        i_pix_ready,
    input logic [mlr_pkg::COORD_W-1:0] i_pix_x,
    input logic [mlr_pkg::COORD_W-1:0] i_pix_y,
    input logic [mlr_pkg::INDEX_W-1:0] i_pix_index,
    input logic                        i_pix_in_frame,
    input logic                        i_pix_last
);
    import mlr_pkg::*;

    // busy right after a segment transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_seg_valid && i_seg_ready) |=> !i_seg_ready)
        else $error("segment input ready right after a transfer");

    // a pixel that is not the last means the walk is still running
    a_no_accept_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix_valid && !i_pix_last) |-> !i_seg_ready)
        else $error("segment input ready while a segment is still emitting");

    // no bubble between pixels of one segment
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix_valid && i_pix_ready && !i_pix_last) |=> i_pix_valid)
        else $error("gap inside a segment's pixel run");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix_valid && !i_pix_ready) |=>
            (i_pix_valid && $stable({i_pix_x, i_pix_y, i_pix_index,
                                     i_pix_in_frame, i_pix_last})))
        else $error("stalled pixel changed");

endmodule

bind midpoint_line_rasterizer_top mlr_checker u_mlr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_seg_valid    (i_seg.valid),
    .i_seg_ready    (i_seg.ready),
    .i_pix_valid    (o_pix.valid),
    .i_pix_ready    (o_pix.ready),
    .i_pix_x        (o_pix.pixel_x),
    .i_pix_y        (o_pix.pixel_y),
    .i_pix_index    (o_pix.pixel_index),
    .i_pix_in_frame (o_pix.in_frame),
    .i_pix_last     (o_pix.last)
);
